// File: rtl/assert_macros.svh
// Assertion helpers for the priority queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check an implication or expression on every clock outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion violated");

// Check that an expression holds on every clock outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, rst, expr)

`endif

`endif

// File: rtl/tlpq_pkg.sv
package tlpq_pkg;

  localparam int CAPACITY = 8;
  localparam int LEVELS   = 3;
  localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DEPTH    = LEVELS * CAPACITY;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int LVL_W    = 2;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPRI = 2'd3;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] value;
    logic        [1:0]  priority_req;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic        [1:0]  status;
    logic        [3:0]  occupancy;
    logic               is_empty;
    logic               is_full;
  } rsp_t;

endpackage

// File: rtl/tlpq_ram.sv
module tlpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 24
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/three_level_priority_queue.sv
// Three-level strict-priority queue.
//
// Request channel (req_valid / req_stall / req): each beat is an enqueue
// (opcode 0, value, priority_req 1..3) or a dequeue (opcode 1). Response
// channel (rsp_valid / rsp_stall / rsp): exactly one beat per request, in
// order, carrying read_value, status, occupancy and the empty/full flags.
// A dequeue takes the oldest word of the highest non-empty level (3 first).
// Full, empty and bad-priority requests are rejected with a status code
// and leave the queue untouched.
//
// Words live in a single-port-write, registered-read RAM of 3 x CAPACITY
// entries; pointers and counts are flops updated on the accepting cycle.
// A request beat passes through the middle stage, where the RAM read lands,
// and then the response register. A new request is taken every cycle
// while the response side keeps draining; a stalled response holds the
// middle stage, and with both stages full the request side stalls.
// Reset empties all levels at once; RAM contents are left as they are and
// no clearing pass is needed.
`include "assert_macros.svh"

module three_level_priority_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  tlpq_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output tlpq_pkg::rsp_t  rsp
);

  import tlpq_pkg::*;

  logic [PTR_W-1:0] head [LEVELS];
  logic [PTR_W-1:0] tail [LEVELS];
  logic [CNT_W-1:0] lcnt [LEVELS];
  logic [CNT_W-1:0] total;

  logic [PTR_W-1:0] head_next [LEVELS];
  logic [PTR_W-1:0] tail_next [LEVELS];
  logic [CNT_W-1:0] lcnt_next [LEVELS];
  logic [CNT_W-1:0] total_next;

  logic             pend_valid;
  logic             pend_read;
  logic [1:0]       pend_status;
  logic [CNT_W-1:0] pend_occ;

  logic             pend_move;
  logic             accept;
  logic [1:0]       status_next;
  logic             ram_we;
  logic             ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]      ram_rdata;
  logic [LVL_W-1:0] enq_lvl;
  logic [LVL_W-1:0] deq_lvl;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(CAPACITY - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  // Response register frees up, then the middle stage, then the request side.
  assign pend_move = pend_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = pend_valid && !pend_move;
  assign accept    = req_valid && !req_stall;

  assign enq_lvl = req.priority_req - LVL_W'(1);

  always_comb begin
    if (lcnt[2] != '0) begin
      deq_lvl = LVL_W'(2);
    end else if (lcnt[1] != '0) begin
      deq_lvl = LVL_W'(1);
    end else begin
      deq_lvl = LVL_W'(0);
    end
  end

  assign ram_waddr = ADDR_W'(enq_lvl) * ADDR_W'(CAPACITY) + ADDR_W'(tail[enq_lvl]);
  assign ram_raddr = ADDR_W'(deq_lvl) * ADDR_W'(CAPACITY) + ADDR_W'(head[deq_lvl]);

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      head_next[i] = head[i];
      tail_next[i] = tail[i];
      lcnt_next[i] = lcnt[i];
    end
    total_next  = total;
    status_next = ST_OK;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    if (accept) begin
      if (req.opcode == OP_ENQ) begin
        if (total >= CNT_W'(CAPACITY)) begin
          status_next = ST_FULL;
        end else if (req.priority_req == 2'd0) begin
          status_next = ST_BADPRI;
        end else begin
          ram_we             = 1'b1;
          tail_next[enq_lvl] = advance(tail[enq_lvl]);
          lcnt_next[enq_lvl] = lcnt[enq_lvl] + CNT_W'(1);
          total_next         = total + CNT_W'(1);
        end
      end else begin
        if (total == '0) begin
          status_next = ST_EMPTY;
        end else begin
          ram_re             = 1'b1;
          head_next[deq_lvl] = advance(head[deq_lvl]);
          lcnt_next[deq_lvl] = lcnt[deq_lvl] - CNT_W'(1);
          total_next         = total - CNT_W'(1);
        end
      end
    end
  end

  tlpq_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(req.value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        lcnt[i] <= '0;
      end
      total      <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i] <= head_next[i];
        tail[i] <= tail_next[i];
        lcnt[i] <= lcnt_next[i];
      end
      total <= total_next;
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload of the middle stage; RAM data for a dequeue lands alongside it.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_read   <= ram_re;
      pend_status <= status_next;
      pend_occ    <= total_next;
    end
    if (pend_move) begin
      rsp.read_value <= pend_read ? ram_rdata : '0;
      rsp.status     <= pend_status;
      rsp.occupancy  <= 4'(pend_occ);
      rsp.is_empty   <= (pend_occ == '0);
      rsp.is_full    <= (pend_occ == CNT_W'(CAPACITY));
    end
  end

  `ASSERT_ALWAYS(a_total_sum, clk, rst,
    total == lcnt[0] + lcnt[1] + lcnt[2])
  `ASSERT_ALWAYS(a_total_cap, clk, rst, total <= CNT_W'(CAPACITY))
  `ASSERT_PROP(a_rdata_hold, clk, rst,
    pend_valid && pend_read && !pend_move |=> $stable(ram_rdata))
  `ASSERT_PROP(a_no_read_when_blocked, clk, rst, ram_re |-> accept)

endmodule
